// ----- sv/tmi_pkg.sv -----
package tmi_pkg;

	// storage sizes
	localparam int TAPE_DEPTH    = 65536;
	localparam int PROGRAM_DEPTH = 4096;

	// tape address, tape fill count, program address, program counter / length
	localparam int TA_W = $clog2(TAPE_DEPTH);
	localparam int TC_W = $clog2(TAPE_DEPTH + 1);
	localparam int PA_W = $clog2(PROGRAM_DEPTH);
	localparam int PC_W = $clog2(PROGRAM_DEPTH + 1);

	// command characters
	localparam logic [7:0] CH_RIGHT = 8'h3E; // '>'
	localparam logic [7:0] CH_LEFT  = 8'h3C; // '<'
	localparam logic [7:0] CH_INC   = 8'h2B; // '+'
	localparam logic [7:0] CH_DEC   = 8'h2D; // '-'
	localparam logic [7:0] CH_OUT   = 8'h2E; // '.'
	localparam logic [7:0] CH_IN    = 8'h2C; // ','
	localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
	localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_STEP    = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_ERASE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HALT    = 3'd1,
		ST_UNDER   = 3'd2,
		ST_OVER    = 3'd3,
		ST_BRACKET = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	// result of one beat, handed from the sequencer to the output register
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		status_t    status;
	} res_t;

endpackage

// ----- sv/tmi_ram.sv -----
module tmi_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/tmi_seq.sv -----
module tmi_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [1:0]                cmd_action,
	input  logic [7:0]                cmd_data,
	output tmi_pkg::res_t             res,
	output logic                      res_pending,
	input  logic                      res_take,
	output logic                      prog_we,
	output logic [tmi_pkg::PA_W-1:0]  prog_waddr,
	output logic [7:0]                prog_wdata,
	output logic [tmi_pkg::PA_W-1:0]  prog_raddr,
	input  logic [7:0]                prog_rdata,
	output logic                      tape_we,
	output logic [tmi_pkg::TA_W-1:0]  tape_addr,
	output logic [7:0]                tape_wdata,
	input  logic [7:0]                tape_rdata
);

	import tmi_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_RESP
	} state_t;

	localparam logic [PC_W-1:0] PROG_FULL = PC_W'(PROGRAM_DEPTH);
	localparam logic [TA_W-1:0] CP_LAST   = TA_W'(TAPE_DEPTH - 1);

	state_t            state_q;
	logic [PC_W-1:0]   len_q;
	logic [PC_W-1:0]   pc_q;
	logic [TA_W-1:0]   cp_q;
	logic [TC_W-1:0]   fill_q;
	status_t           fault_q;
	logic [7:0]        byte_q;
	logic              fwd_q;
	logic [PA_W-1:0]   idx_q;
	logic [PC_W-1:0]   level_q;
	res_t              res_q;

	action_t           act;
	logic              cell_live;
	logic [7:0]        cell_val;
	logic              cp_at_fill;
	logic [PC_W-1:0]   idx_step;
	logic              scan_off_end;
	logic [PC_W-1:0]   level_nxt;

	assign act = action_t'(cmd_action);

	// cells at or above the fill count were never reached since restart: read as zero
	assign cell_live  = {1'b0, cp_q} < fill_q;
	assign cell_val   = cell_live ? tape_rdata : 8'h00;
	assign cp_at_fill = {1'b0, cp_q} == fill_q;

	// scan unit: one index step and one level step per character
	assign idx_step     = fwd_q ? ({1'b0, idx_q} + PC_W'(1)) : ({1'b0, idx_q} - PC_W'(1));
	assign scan_off_end = fwd_q ? (idx_step >= len_q) : (idx_q == '0);

	always_comb begin
		level_nxt = level_q;
		if (prog_rdata == CH_OPEN) begin
			level_nxt = fwd_q ? (level_q + PC_W'(1)) : (level_q - PC_W'(1));
		end else if (prog_rdata == CH_CLOSE) begin
			level_nxt = fwd_q ? (level_q - PC_W'(1)) : (level_q + PC_W'(1));
		end
	end

	assign cmd_ready   = (state_q == S_IDLE);
	assign res_pending = (state_q == S_RESP);
	assign res         = res_q;

	// program store ports
	assign prog_we    = (state_q == S_IDLE) && cmd_valid && (act == ACT_LOAD) &&
	                    (len_q < PROG_FULL);
	assign prog_waddr = len_q[PA_W-1:0];
	assign prog_wdata = cmd_data;
	assign prog_raddr = (state_q == S_SCAN_RD) ? idx_step[PA_W-1:0] : pc_q[PA_W-1:0];

	// tape port: read in idle, read-modify-write in exec
	// a '>' off the fill edge zeroes that cell so the fill count never falls behind the pointer
	assign tape_addr = cp_q;
	assign tape_we   = (state_q == S_EXEC) &&
	                   ((prog_rdata == CH_INC) || (prog_rdata == CH_DEC) ||
	                    (prog_rdata == CH_IN) ||
	                    ((prog_rdata == CH_RIGHT) && cp_at_fill));

	always_comb begin
		case (prog_rdata)
			CH_INC:  tape_wdata = cell_val + 8'd1;
			CH_DEC:  tape_wdata = cell_val - 8'd1;
			CH_IN:   tape_wdata = byte_q;
			default: tape_wdata = cell_val;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			len_q           <= '0;
			pc_q            <= '0;
			cp_q            <= '0;
			fill_q          <= '0;
			fault_q         <= ST_OK;
			byte_q          <= '0;
			fwd_q           <= 1'b0;
			idx_q           <= '0;
			level_q         <= '0;
			res_q.out_valid <= 1'b0;
			res_q.out_byte  <= '0;
			res_q.status    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						byte_q          <= cmd_data;
						res_q.out_valid <= 1'b0;
						res_q.out_byte  <= '0;
						res_q.status    <= ST_OK;
						state_q         <= S_RESP;
						unique case (act)
							ACT_LOAD: begin
								if (len_q < PROG_FULL) begin
									len_q        <= len_q + PC_W'(1);
									res_q.status <= fault_q;
								end else if (fault_q == ST_OK) begin
									fault_q      <= ST_FULL;
									res_q.status <= ST_FULL;
								end else begin
									res_q.status <= fault_q;
								end
							end
							ACT_STEP: begin
								if (fault_q != ST_OK) begin
									res_q.status <= fault_q;
								end else if (pc_q >= len_q) begin
									res_q.status <= ST_HALT;
								end else begin
									state_q <= S_EXEC;
								end
							end
							ACT_RESTART: begin
								fill_q  <= '0;
								cp_q    <= '0;
								pc_q    <= '0;
								fault_q <= ST_OK;
							end
							ACT_ERASE: begin
								len_q   <= '0;
								pc_q    <= '0;
								fault_q <= ST_OK;
							end
							default: begin
							end
						endcase
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					unique case (prog_rdata)
						CH_RIGHT: begin
							if (cp_q == CP_LAST) begin
								fault_q      <= ST_OVER;
								res_q.status <= ST_OVER;
							end else begin
								if (cp_at_fill) begin
									fill_q <= fill_q + TC_W'(1);
								end
								cp_q <= cp_q + TA_W'(1);
								pc_q <= pc_q + PC_W'(1);
							end
						end
						CH_LEFT: begin
							if (cp_q == '0) begin
								fault_q      <= ST_UNDER;
								res_q.status <= ST_UNDER;
							end else begin
								cp_q <= cp_q - TA_W'(1);
								pc_q <= pc_q + PC_W'(1);
							end
						end
						CH_INC, CH_DEC, CH_IN: begin
							if (cp_at_fill) begin
								fill_q <= fill_q + TC_W'(1);
							end
							pc_q <= pc_q + PC_W'(1);
						end
						CH_OUT: begin
							res_q.out_byte  <= cell_val;
							res_q.out_valid <= 1'b1;
							pc_q            <= pc_q + PC_W'(1);
						end
						CH_OPEN: begin
							if (cell_val == 8'h00) begin
								fwd_q   <= 1'b1;
								idx_q   <= pc_q[PA_W-1:0];
								level_q <= PC_W'(1);
								state_q <= S_SCAN_RD;
							end else begin
								pc_q <= pc_q + PC_W'(1);
							end
						end
						CH_CLOSE: begin
							if (cell_val != 8'h00) begin
								fwd_q   <= 1'b0;
								idx_q   <= pc_q[PA_W-1:0];
								level_q <= PC_W'(1);
								state_q <= S_SCAN_RD;
							end else begin
								pc_q <= pc_q + PC_W'(1);
							end
						end
						default: begin
							pc_q <= pc_q + PC_W'(1);
						end
					endcase
				end
				S_SCAN_RD: begin
					if (scan_off_end) begin
						fault_q      <= ST_BRACKET;
						res_q.status <= ST_BRACKET;
						state_q      <= S_RESP;
					end else begin
						idx_q   <= idx_step[PA_W-1:0];
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (level_nxt == '0) begin
						pc_q    <= {1'b0, idx_q} + PC_W'(1);
						state_q <= S_RESP;
					end else begin
						level_q <= level_nxt;
						state_q <= S_SCAN_RD;
					end
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cp_within_fill: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cp_q} <= fill_q)
		else $error("cell pointer beyond tape fill count");

	a_pc_within_len: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= len_q)
		else $error("program counter beyond program length");

	a_scan_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_RD || state_q == S_SCAN_CHK) |-> (level_q != '0))
		else $error("bracket scan running with zero nesting level");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cmd_valid && act == ACT_STEP && fault_q != ST_OK)
		|=> (state_q == S_RESP && res_q.status == $past(fault_q) &&
		     pc_q == $past(pc_q) && cp_q == $past(cp_q)))
		else $error("step under a standing fault changed machine state");
`endif

endmodule

// ----- sv/tape_machine_interpreter_unit.sv -----
// tape machine interpreter: a byte-tape machine running a stored 8-command program
// input channel (item_valid / item_ready) takes one beat per command:
//   action 0 appends data_byte to the program store, 1 executes one program
//   character (data_byte feeds ','), 2 restarts the run, 3 erases the program
// output channel (result_valid / result_ready) returns exactly one beat per input
//   beat: out_byte / out_valid for '.', status for ok, halt or the sticky fault
// from input accept to result: load, restart, erase and stepping under a fault or
//   past the end go straight to the response state; an ordinary step passes
//   through execute (program read plus one tape read-modify-write); a bracket
//   that jumps walks the program in a read and a check state per character, reading
//   program memory once per character; a scan off the end faults in its read state
// one command is in flight at a time; item_ready is high only while the sequencer
//   is idle, so a new beat waits until the last result has left the sequencer
// if the receiver stalls, the result holds in the output register and the next
//   finished result waits in the sequencer until that register frees up
// reset clears pointer, program counter, length and fault; tape cells read as zero
//   until first reached, tracked by a fill count, so reset and restart take no
//   clearing pass
module tape_machine_interpreter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic [2:0] status
);

	import tmi_pkg::*;

	res_t            res;
	logic            res_pending;
	logic            res_take;

	// program store port
	logic            prog_we;
	logic [PA_W-1:0] prog_waddr;
	logic [7:0]      prog_wdata;
	logic [PA_W-1:0] prog_raddr;
	logic [7:0]      prog_rdata;

	// tape port
	logic            tape_we;
	logic [TA_W-1:0] tape_addr;
	logic [7:0]      tape_wdata;
	logic [7:0]      tape_rdata;

	// output register
	logic            result_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_valid_q;
	logic [2:0]      status_q;

	// output register takes a new beat when empty or being drained this cycle
	assign res_take = !result_valid_q || result_ready;

	tmi_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (item_valid),
		.cmd_ready   (item_ready),
		.cmd_action  (action),
		.cmd_data    (data_byte),
		.res         (res),
		.res_pending (res_pending),
		.res_take    (res_take),
		.prog_we     (prog_we),
		.prog_waddr  (prog_waddr),
		.prog_wdata  (prog_wdata),
		.prog_raddr  (prog_raddr),
		.prog_rdata  (prog_rdata),
		.tape_we     (tape_we),
		.tape_addr   (tape_addr),
		.tape_wdata  (tape_wdata),
		.tape_rdata  (tape_rdata)
	);

	// program store: written by loads, read by fetch and bracket scan
	tmi_ram #(
		.DEPTH (PROGRAM_DEPTH),
		.WIDTH (8)
	) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (prog_waddr),
		.wdata (prog_wdata),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	// tape: read at the cell pointer on accept, written back during execute
	tmi_ram #(
		.DEPTH (TAPE_DEPTH),
		.WIDTH (8)
	) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_addr),
		.wdata (tape_wdata),
		.raddr (tape_addr),
		.rdata (tape_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_pending && res_take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_pending && res_take) begin
			out_byte_q  <= res.out_byte;
			out_valid_q <= res.out_valid;
			status_q    <= res.status;
		end
	end

	assign result_valid = result_valid_q;
	assign out_byte     = out_byte_q;
	assign out_valid    = out_valid_q;
	assign status       = status_q;

endmodule

// ----- test/tape_machine_interpreter_unit_test.sv -----
`timescale 1ns / 100ps

module tape_machine_interpreter_unit_test;
	import tmi_pkg::*;

	// one row of the directed table: the beat to send and, where it is obvious,
	// the result typed in by hand
	typedef struct packed {
		action_t    act;
		logic [7:0] arg;
		logic       typed;
		logic [7:0] exp_byte;
		logic       exp_valid;
		status_t    exp_status;
	} vector_t;

	// receiver stall patterns
	typedef enum int {RX_EAGER, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_t;

	// directed opening: empty program, emits, ',' with all ones, underflow,
	// sticky fault on step and load, restart, erase, unmatched brackets both ways
	localparam vector_t DIRECTED_TAB [24] = '{
		'{ACT_STEP,    8'h5A,    1'b1, 8'h00, 1'b0, ST_HALT},    // nothing loaded yet
		'{ACT_LOAD,    CH_INC,   1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_LOAD,    CH_OUT,   1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_LOAD,    CH_IN,    1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_LOAD,    CH_OUT,   1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_LOAD,    CH_LEFT,  1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_STEP,    8'h00,    1'b0, 8'h00, 1'b0, ST_OK},      // '+'
		'{ACT_STEP,    8'h00,    1'b1, 8'h01, 1'b1, ST_OK},      // '.' emits one
		'{ACT_STEP,    8'hFF,    1'b0, 8'h00, 1'b0, ST_OK},      // ',' takes all ones
		'{ACT_STEP,    8'h00,    1'b1, 8'hFF, 1'b1, ST_OK},
		'{ACT_STEP,    8'h00,    1'b1, 8'h00, 1'b0, ST_UNDER},   // '<' at cell zero
		'{ACT_STEP,    8'h3C,    1'b1, 8'h00, 1'b0, ST_UNDER},   // fault holds
		'{ACT_LOAD,    8'h00,    1'b1, 8'h00, 1'b0, ST_UNDER},   // load reports the fault
		'{ACT_RESTART, 8'hFF,    1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_ERASE,   8'h00,    1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_LOAD,    CH_OPEN,  1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_STEP,    8'h00,    1'b1, 8'h00, 1'b0, ST_BRACKET}, // forward scan runs off
		'{ACT_ERASE,   8'hFF,    1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_LOAD,    CH_DEC,   1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_LOAD,    CH_CLOSE, 1'b1, 8'h00, 1'b0, ST_OK},
		'{ACT_STEP,    8'h00,    1'b0, 8'h00, 1'b0, ST_OK},      // '-' wraps to all ones
		'{ACT_STEP,    8'h00,    1'b1, 8'h00, 1'b0, ST_BRACKET}, // backward scan runs off
		'{ACT_LOAD,    CH_RIGHT, 1'b1, 8'h00, 1'b0, ST_BRACKET},
		'{ACT_RESTART, 8'h00,    1'b1, 8'h00, 1'b0, ST_OK}
	};

	// block ports
	logic       clk = 1'b0;
	logic       arst_n;
	logic       item_valid = 1'b0;
	logic       item_ready;
	action_t    action = ACT_LOAD;
	logic [7:0] data_byte = 8'h00;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_valid;
	logic [2:0] status;

	// machine state as the testbench sees it
	logic [7:0]      prog_mem [PROGRAM_DEPTH];
	logic [PC_W-1:0] prog_len = '0;
	logic [PC_W-1:0] prog_cnt = '0;
	logic [7:0]      tape_mem [TAPE_DEPTH];
	// a cell is live only if written since the last restart, so a restart
	// just bumps the run number instead of clearing the whole tape
	int unsigned     tape_epoch [TAPE_DEPTH];
	int unsigned     run_epoch = 1;
	logic [TA_W-1:0] cell_ptr = '0;
	status_t         fault = ST_OK;

	// results still owed by the block, oldest first
	res_t        expected_q [$];
	int          error_count = 0;
	int          beats_sent = 0;
	logic [7:0]  script_q [$];

	// traffic shaping
	bit          steady_run = 1'b0;
	int          burst_left = 0;
	rx_mode_t    rx_mode = RX_EAGER;
	int          mode_left = 0;
	int          rx_tick = 0;
	int          holdoff_left = 0;
	int          results_seen = 0;
	res_t        rx_want;

	tape_machine_interpreter_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.status       (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run off past the end of the program is a fault, same as the block
	function automatic bit find_partner(input bit fwd, output logic [PC_W-1:0] where);
		int idx;
		int depth;
		idx = int'(prog_cnt);
		depth = 1;
		where = prog_cnt;
		while (depth > 0) begin
			if (fwd) begin
				if (idx + 1 >= int'(prog_len))
					return 1'b0;
				idx++;
			end else begin
				if (idx == 0)
					return 1'b0;
				idx--;
			end
			if (prog_mem[idx] == CH_OPEN)
				depth += fwd ? 1 : -1;
			else if (prog_mem[idx] == CH_CLOSE)
				depth += fwd ? -1 : 1;
		end
		where = PC_W'(idx);
		return 1'b1;
	endfunction

	task automatic store_cell(input logic [7:0] v);
		tape_mem[cell_ptr] = v;
		tape_epoch[cell_ptr] = run_epoch;
	endtask

	// one beat of the machine: updates the state and gives the result it owes
	task automatic interpret(input action_t act, input logic [7:0] arg, output res_t r);
		logic [7:0]      op;
		logic [7:0]      cell_val;
		logic [PC_W-1:0] hit;
		r.out_byte = 8'h00;
		r.out_valid = 1'b0;
		r.status = ST_OK;
		case (act)
			ACT_LOAD: begin
				if (prog_len < PROGRAM_DEPTH) begin
					prog_mem[prog_len[PA_W-1:0]] = arg;
					prog_len++;
				end else if (fault == ST_OK) begin
					fault = ST_FULL;
				end
				r.status = fault;
			end
			ACT_STEP: begin
				if (fault != ST_OK) begin
					r.status = fault;
				end else if (prog_cnt >= prog_len) begin
					r.status = ST_HALT;
				end else begin
					op = prog_mem[prog_cnt[PA_W-1:0]];
					cell_val = (tape_epoch[cell_ptr] == run_epoch) ? tape_mem[cell_ptr] : 8'h00;
					case (op)
						CH_RIGHT: begin
							if (int'(cell_ptr) == TAPE_DEPTH - 1)
								fault = ST_OVER;
							else
								cell_ptr++;
						end
						CH_LEFT: begin
							if (cell_ptr == '0)
								fault = ST_UNDER;
							else
								cell_ptr--;
						end
						CH_INC: store_cell(cell_val + 8'd1);
						CH_DEC: store_cell(cell_val - 8'd1);
						CH_OUT: begin
							r.out_byte = cell_val;
							r.out_valid = 1'b1;
						end
						CH_IN: store_cell(arg);
						CH_OPEN: begin
							if (cell_val == 8'h00) begin
								if (find_partner(1'b1, hit))
									prog_cnt = hit;
								else
									fault = ST_BRACKET;
							end
						end
						CH_CLOSE: begin
							if (cell_val != 8'h00) begin
								if (find_partner(1'b0, hit))
									prog_cnt = hit;
								else
									fault = ST_BRACKET;
							end
						end
						default: ;
					endcase
					if (fault != ST_OK)
						r.status = fault;
					else
						prog_cnt++;
				end
			end
			ACT_RESTART: begin
				run_epoch++;
				cell_ptr = '0;
				prog_cnt = '0;
				fault = ST_OK;
			end
			default: begin
				prog_len = '0;
				prog_cnt = '0;
				fault = ST_OK;
			end
		endcase
	endtask

	// offer one beat, wait for the handshake, then log what the block owes for it
	task automatic send_beat(input action_t act, input logic [7:0] arg, input bit typed,
			input res_t typed_res);
		res_t predicted;
		if (!steady_run) begin
			// sender idles between bursts of random length
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 8);
			end
			burst_left--;
		end
		item_valid <= 1'b1;
		action <= act;
		data_byte <= arg;
		do @(posedge clk); while (!item_ready);
		interpret(act, arg, predicted);
		expected_q.push_back(typed ? typed_res : predicted);
		beats_sent++;
	endtask

	task automatic issue(input action_t act, input logic [7:0] arg);
		send_beat(act, arg, 1'b0, '0);
	endtask

	// any command character but the brackets, or a no-op
	function automatic logic [7:0] plain_command();
		case ($urandom_range(0, 6))
			0: return CH_INC;
			1: return CH_DEC;
			2: return CH_RIGHT;
			3: return CH_OUT;
			4: return CH_IN;
			5: return CH_LEFT;
			default: return 8'h20;
		endcase
	endfunction

	// short program with mostly nested, balanced loops and the odd stray bracket
	task automatic compose_program(input int len);
		int depth;
		int roll;
		script_q.delete();
		depth = 0;
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 10 && depth < 3) begin
				script_q.push_back(CH_OPEN);
				depth++;
			end else if (roll >= 10 && roll < 20 && depth > 0) begin
				script_q.push_back(CH_CLOSE);
				depth--;
			end else if (roll >= 10 && roll < 12) begin
				script_q.push_back(CH_CLOSE);
			end else if (roll < 38) begin
				script_q.push_back(CH_INC);
			end else if (roll < 50) begin
				script_q.push_back(CH_DEC);
			end else if (roll < 62) begin
				script_q.push_back(CH_RIGHT);
			end else if (roll < 68) begin
				script_q.push_back(CH_LEFT);
			end else if (roll < 82) begin
				script_q.push_back(CH_OUT);
			end else if (roll < 92) begin
				script_q.push_back(CH_IN);
			end else begin
				script_q.push_back(8'($urandom));
			end
		end
		// most programs close their loops, a few leave them open
		if ($urandom_range(0, 9) != 0) begin
			while (depth > 0) begin
				script_q.push_back(CH_CLOSE);
				depth--;
			end
		end
	endtask

	// result side: check every beat, stall on a pattern of its own
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result beat: out_byte=%h out_valid=%b status=%0d",
							out_byte, out_valid, status);
				end else begin
					rx_want = expected_q.pop_front();
					if (out_byte !== rx_want.out_byte || out_valid !== rx_want.out_valid
							|| status !== rx_want.status) begin
						error_count++;
						if (error_count <= 10)
							$display("result %0d mismatch: expected byte=%h valid=%b status=%0d, got byte=%h valid=%b status=%0d",
								results_seen, rx_want.out_byte, rx_want.out_valid,
								rx_want.status, out_byte, out_valid, status);
					end
				end
				// long hold-off so the block backs up into its input
				if (results_seen == 400 || results_seen == 1200)
					holdoff_left = 300;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				result_ready <= 1'b0;
			end else if (steady_run) begin
				result_ready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				rx_tick++;
				case (rx_mode)
					RX_EAGER:    result_ready <= 1'b1;
					RX_COIN:     result_ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: result_ready <= (rx_tick % 7) >= 3;
					default:     result_ready <= $urandom_range(0, 9) != 0;
				endcase
			end
		end
	end

	initial begin
		vector_t row;
		res_t    typed_res;
		int      goal;
		int      roll;
		int      n_steps;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		for (int i = 0; i < $size(DIRECTED_TAB); i++) begin
			row = DIRECTED_TAB[i];
			typed_res.out_byte = row.exp_byte;
			typed_res.out_valid = row.exp_valid;
			typed_res.status = row.exp_status;
			send_beat(row.act, row.arg, row.typed, typed_res);
		end

		// random part: mostly load-then-run sequences, some plain noise,
		// leaving room for the back-to-back stretch at the end
		goal = 1500;
		while (beats_sent < goal) begin
			if ($urandom_range(0, 99) < 12) begin
				repeat ($urandom_range(1, 5))
					issue(action_t'($urandom_range(0, 3)), 8'($urandom));
			end else begin
				// sometimes append to the old program instead of starting over
				if ($urandom_range(0, 3) != 0)
					issue(ACT_ERASE, 8'($urandom));
				if ($urandom_range(0, 1) != 0)
					issue(ACT_RESTART, 8'($urandom));
				compose_program($urandom_range(3, 30));
				foreach (script_q[k])
					issue(ACT_LOAD, script_q[k]);
				n_steps = $urandom_range(4, 70);
				for (int s = 0; s < n_steps; s++) begin
					roll = $urandom_range(0, 99);
					if (roll < 3)
						issue(ACT_RESTART, 8'($urandom));
					else if (roll < 6)
						issue(ACT_LOAD, plain_command());
					else
						issue(ACT_STEP, 8'($urandom));
					// usually stop soon after the program halts or faults
					if ((fault != ST_OK || prog_cnt >= prog_len) && $urandom_range(0, 2) == 0)
						break;
				end
			end
		end

		// back-to-back stretch: no sender gaps and an eager receiver
		steady_run = 1'b1;
		issue(ACT_ERASE, 8'($urandom));
		issue(ACT_RESTART, 8'($urandom));
		compose_program(20);
		foreach (script_q[k])
			issue(ACT_LOAD, script_q[k]);
		repeat (30) issue(ACT_STEP, 8'($urandom));
		steady_run = 1'b0;
		issue(ACT_RESTART, 8'($urandom));
		issue(ACT_STEP, 8'($urandom));

		// drain
		item_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0)
			$display("tape_machine_interpreter_unit_test: PASS");
		else
			$display("tape_machine_interpreter_unit_test: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#(40_000_000);
		$display("tape_machine_interpreter_unit_test: FAIL");
		$finish;
	end

endmodule
